[rtl/ibcrsf_pkg.sv]
// Shared types and constants for the iBUS to CRSF bridge.
`default_nettype none
package ibcrsf_pkg;
  localparam logic [7:0] SYNC1 = 8'h20;
  localparam logic [7:0] SYNC2 = 8'h40;
  localparam logic [7:0] CRSF_LEN = 8'd24;
  localparam logic [7:0] CRSF_TYPE = 8'h16;
  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] ADDR_RESET = 8'hEC;
  localparam logic [10:0] CH_RESET = 11'd992;
  localparam logic [10:0] CH_MIN = 11'd172;
  localparam logic [10:0] CH_MAX = 11'd1811;
  localparam int NUM_OUT_CH = 16;
  localparam int NUM_STAGED = 14;
  localparam int FRAME_LEN = 25;

  typedef enum logic [1:0] {
    HUNT_SYNC1 = 2'd0,
    HUNT_SYNC2 = 2'd1,
    HUNT_COLLECT = 2'd2,
    HUNT_SPARE = 2'd3
  } hunt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_MUL,
    ST_SCALE_DIV,
    ST_SCALE_WR,
    ST_TX
  } state_t;

  // Advance the CRC-8 (polynomial 0xD5) over one byte.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int j = 0; j < 8; j++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

[rtl/ibcrsf_scale.sv]
// Shared scaling unit: multiply, then divide by 1000 via reciprocal, then clamp.
`default_nettype none
module ibcrsf_scale (
  input  wire logic        clk,
  input  wire logic [15:0] raw,
  input  wire logic        load,
  input  wire logic        div_load,
  output logic      [10:0] result
);
  import ibcrsf_pkg::*;
  // ceil(2^37 / 1000)
  localparam logic [27:0] RECIP = 28'd137438954;

  logic signed [31:0] prod_r;
  logic signed [31:0] prod_nxt;
  logic        [26:0] mag;
  logic        [54:0] recip;
  logic        [17:0] q_r;
  logic        [17:0] q_nxt;
  logic               neg_r;
  logic signed [19:0] v;

  assign prod_nxt = ($signed({16'd0, raw}) - 32'sd1000) * 32'sd1639;
  always_ff @(posedge clk) begin
    if (load) prod_r <= prod_nxt;
  end

  // |prod| < 2^27, so the reciprocal estimate is off by less than 1/1000: exact floor
  assign mag = prod_r[31] ? 27'(-prod_r) : 27'(prod_r);
  assign recip = mag * RECIP;
  assign q_nxt = recip[54:37];
  always_ff @(posedge clk) begin
    if (div_load) begin
      q_r <= q_nxt;
      neg_r <= prod_r[31];
    end
  end

  assign v = (neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r})) + 20'sd172;

  always_comb begin
    if (v < 20'sd172) result = CH_MIN;
    else if (v > 20'sd1811) result = CH_MAX;
    else result = v[10:0];
  end
endmodule
`default_nettype wire

[rtl/ibus_to_crsf_channel_bridge_unit.sv]
// Top level of the iBUS to CRSF RC-channels bridge.
// Byte word: accepted while idle; after a good frame, each channel passes through multiply,
// reciprocal divide and write states in one shared scale unit, not ready meanwhile.
// Tick word: 25 output words, one per cycle while out_tready is high, CRC built bytewise.
// Reset (rst_n low, synchronous): parser hunts, channels read 992, address 0xEC.
`default_nettype none
module ibus_to_crsf_channel_bridge_unit #(
  parameter int INPUT_CHANNELS = 14
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // rx_byte
  input  wire logic       in_tuser,   // mode
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // tx_byte
  output logic            out_tlast,  // last_byte
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  import ibcrsf_pkg::*;
  localparam int NCH = (INPUT_CHANNELS < NUM_STAGED) ? INPUT_CHANNELS : NUM_STAGED;

  state_t state_r, state_nxt;
  hunt_t hunt_r;
  logic [4:0] pos_r;
  logic [15:0] sum_r;
  logic [7:0] held_r;
  logic [15:0] staged_r [NUM_STAGED];
  logic [10:0] ch_r [NUM_OUT_CH];
  logic [7:0] addr_r;
  logic [3:0] ch_idx_r;
  logic [4:0] tx_idx_r;
  logic [7:0] crc_r;
  logic [175:0] flat;
  logic [7:0] pay;
  logic [10:0] scaled;
  logic acc_in, acc_out, good;

  for (genvar g = 0; g < NUM_OUT_CH; g++) begin : g_flat
    assign flat[g*11 +: 11] = ch_r[g];
  end

  ibcrsf_scale u_scale (
    .clk(clk), .raw(staged_r[ch_idx_r]), .load(state_r == ST_SCALE_MUL),
    .div_load(state_r == ST_SCALE_DIV), .result(scaled)
  );

  assign acc_in = in_tvalid && in_tready;
  assign acc_out = out_tvalid && out_tready;
  assign good = (sum_r == {in_tdata, held_r});
  assign pay = (tx_idx_r >= 5'd3 && tx_idx_r <= 5'd24) ? flat[(tx_idx_r - 5'd3) * 8 +: 8] : 8'd0;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    out_tlast = 1'b0;
    out_tdata = 8'd0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (acc_in) begin
          if (in_tuser) state_nxt = ST_TX;
          else if (hunt_r == HUNT_COLLECT && pos_r == 5'd29 && good) state_nxt = ST_SCALE_MUL;
        end
      end
      ST_SCALE_MUL: state_nxt = ST_SCALE_DIV;
      ST_SCALE_DIV: state_nxt = ST_SCALE_WR;
      ST_SCALE_WR: state_nxt = (32'(ch_idx_r) == NCH - 1) ? ST_IDLE : ST_SCALE_MUL;
      ST_TX: begin
        out_tvalid = 1'b1;
        out_tlast = (tx_idx_r == 5'd24);
        unique case (tx_idx_r)
          5'd0: out_tdata = addr_r;
          5'd1: out_tdata = CRSF_LEN;
          5'd2: out_tdata = CRSF_TYPE;
          // last payload byte is covered by the CRC but replaced by it on the wire
          5'd24: out_tdata = crc_step(crc_r, pay);
          default: out_tdata = pay;
        endcase
        if (acc_out && out_tlast) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r <= HUNT_SYNC1;
      pos_r <= 5'd0;
      sum_r <= 16'hFFFF;
      addr_r <= ADDR_RESET;
      ch_idx_r <= 4'd0;
      tx_idx_r <= 5'd0;
      crc_r <= 8'd0;
      for (int i = 0; i < NUM_OUT_CH; i++) ch_r[i] <= CH_RESET;
    end else begin
      if (cfg_we) addr_r <= cfg_wdata;
      if (acc_in && !in_tuser) begin
        unique case (hunt_r)
          HUNT_SYNC2: begin
            if (in_tdata == SYNC2) begin
              hunt_r <= HUNT_COLLECT;
              pos_r <= 5'd0;
              sum_r <= 16'hFFFF - 16'h0060;
            end else hunt_r <= HUNT_SYNC1;
          end
          HUNT_COLLECT: begin
            if (pos_r < 5'd28) begin
              sum_r <= sum_r - {8'd0, in_tdata};
              pos_r <= pos_r + 5'd1;
            end else if (pos_r == 5'd28) pos_r <= 5'd29;
            else begin
              hunt_r <= HUNT_SYNC1;
              pos_r <= 5'd0;
            end
          end
          default: hunt_r <= (in_tdata == SYNC1) ? HUNT_SYNC2 : HUNT_SYNC1;
        endcase
      end
      if (state_r == ST_SCALE_WR) begin
        ch_r[ch_idx_r] <= scaled;
        ch_idx_r <= (state_nxt == ST_IDLE) ? 4'd0 : ch_idx_r + 4'd1;
      end
      if (acc_in && in_tuser) begin
        tx_idx_r <= 5'd0;
        crc_r <= 8'd0;
      end
      if (acc_out) begin
        tx_idx_r <= out_tlast ? 5'd0 : tx_idx_r + 5'd1;
        if (tx_idx_r >= 5'd2 && tx_idx_r <= 5'd23) crc_r <= crc_step(crc_r, out_tdata);
      end
    end
  end

  // Held byte and staged words carry no reset.
  always_ff @(posedge clk) begin
    if (acc_in && !in_tuser && hunt_r == HUNT_COLLECT) begin
      if (pos_r < 5'd28 && !pos_r[0]) held_r <= in_tdata;
      else if (pos_r < 5'd28) staged_r[pos_r[4:1]] <= {in_tdata, held_r};
      else if (pos_r == 5'd28) held_r <= in_tdata;
    end
  end

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_tx_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == ST_TX)) else $error("output outside frame");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_out && out_tlast) |=> (state_r == ST_IDLE)) else $error("frame did not end");
`endif
endmodule
`default_nettype wire

[test/ibus_to_crsf_channel_bridge_unit_tb.sv]
// Self-checking testbench for the iBUS to CRSF bridge: frame parsing, scaling and frame output.
`default_nettype none
module ibus_to_crsf_channel_bridge_unit_tb;
  import ibcrsf_pkg::*;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } frame_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  ibus_to_crsf_channel_bridge_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predictor state
  logic [7:0]  addr_m;
  hunt_t       phase_m;
  logic [4:0]  pos_m;
  logic [15:0] sum_m;
  logic [7:0]  low_m;
  logic [15:0] raw_m [NUM_STAGED];
  logic [10:0] chan_m [NUM_OUT_CH];

  frame_word_t frame_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int gap_max = 3;

  function automatic logic [10:0] scale_raw(input logic [15:0] raw);
    int v;
    v = ((int'(raw) - 1000) * 1639) / 1000 + 172;
    if (v < 172) v = 172;
    if (v > 1811) v = 1811;
    return v[10:0];
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (phase_m)
      HUNT_SYNC2: begin
        if (b == SYNC2) begin
          phase_m = HUNT_COLLECT;
          pos_m = 5'd0;
          sum_m = 16'hFFFF - 16'h20 - 16'h40;
        end else begin
          phase_m = HUNT_SYNC1;
        end
      end
      HUNT_COLLECT: begin
        if (pos_m < 5'd28) begin
          sum_m = sum_m - {8'd0, b};
          if (!pos_m[0]) low_m = b;
          else raw_m[pos_m[4:1]] = {b, low_m};
          pos_m = pos_m + 5'd1;
        end else if (pos_m == 5'd28) begin
          low_m = b;
          pos_m = 5'd29;
        end else begin
          if (sum_m == {b, low_m})
            for (int i = 0; i < 14 && i < NUM_STAGED; i++) chan_m[i] = scale_raw(raw_m[i]);
          phase_m = HUNT_SYNC1;
          pos_m = 5'd0;
        end
      end
      default: phase_m = (b == SYNC1) ? HUNT_SYNC2 : HUNT_SYNC1;
    endcase
  endfunction

  function automatic void queue_frame();
    logic [7:0] f [FRAME_LEN];
    logic [7:0] crc;
    int p;
    for (int i = 0; i < FRAME_LEN; i++) f[i] = '0;
    f[0] = addr_m;
    f[1] = CRSF_LEN;
    f[2] = CRSF_TYPE;
    for (int i = 0; i < NUM_OUT_CH; i++)
      for (int k = 0; k < 11; k++) begin
        p = i * 11 + k;
        if (chan_m[i][k]) f[3 + p / 8][p % 8] = 1'b1;
      end
    // CRC covers the type and all 22 payload bytes; the last one is then replaced
    crc = '0;
    for (int i = 2; i < FRAME_LEN; i++) begin
      crc = crc ^ f[i];
      for (int j = 0; j < 8; j++) crc = crc[7] ? ((crc << 1) ^ 8'hD5) : (crc << 1);
    end
    f[24] = crc;
    for (int i = 0; i < FRAME_LEN; i++) frame_q.push_back('{f[i], i == FRAME_LEN - 1});
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Drive one word; predict at acceptance.
  task automatic send_word(input logic mode, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 5) == 0 ? $urandom_range(1, gap_max) : 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode) queue_frame();
    else parse_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] ch [14], input bit corrupt);
    logic [15:0] s;
    s = 16'hFFFF - 16'h60;
    send_word(1'b0, SYNC1);
    send_word(1'b0, SYNC2);
    for (int i = 0; i < 14; i++) begin
      send_word(1'b0, ch[i][7:0]);
      send_word(1'b0, ch[i][15:8]);
      s = s - {8'd0, ch[i][7:0]} - {8'd0, ch[i][15:8]};
    end
    if (corrupt) s = s ^ (16'd1 << $urandom_range(0, 15));
    send_word(1'b0, s[7:0]);
    send_word(1'b0, s[15:8]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(negedge clk);
    cfg_we <= 1'b0;
    addr_m = a;
  endtask

  task automatic test_directed();
    logic [15:0] ch [14];
    send_word(1'b1, 8'hFF);
    for (int i = 0; i < 14; i++) ch[i] = (i % 3 == 0) ? 16'd0 : (i % 3 == 1) ? 16'hFFFF : 16'd1500;
    ch[3] = 16'd1000; ch[4] = 16'd999; ch[5] = 16'd2000; ch[6] = 16'd1001;
    send_frame(ch, 1'b0);
    send_word(1'b1, 8'h00);
    // wrong second sync byte, then a sync byte not re-examined
    send_word(1'b0, SYNC1);
    send_word(1'b0, SYNC1);
    send_word(1'b0, SYNC2);
    send_word(1'b1, 8'h55);
  endtask

  task automatic test_bad_checksum();
    logic [15:0] ch [14];
    for (int i = 0; i < 14; i++) ch[i] = 16'($urandom_range(800, 2200));
    send_frame(ch, 1'b1);
    send_word(1'b1, 8'h00);
  endtask

  task automatic test_random(input int n);
    logic [15:0] ch [14];
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 11)) inside
        [0:6]: send_word(1'b0, 8'($urandom));
        [7:10]: send_word(1'b1, 8'($urandom));
        default: begin
          for (int i = 0; i < 14; i++)
            ch[i] = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(900, 2100));
          send_frame(ch, $urandom_range(0, 3) == 0);
          send_word(1'b1, 8'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    gap_max = 1;
    for (int i = 0; i < 4; i++) send_word(1'b1, 8'($urandom));
    while (hold_off) @(negedge clk);
    gap_max = 20;
    wait_drained();
  endtask

  // Receiver stall pattern and long hold-off.
  always @(negedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
      idle_cycles++;
      if (idle_cycles > 200) begin
        hold_off = 1'b0;
        idle_cycles = 0;
      end
    end else begin
      out_tready <= ($urandom_range(0, 15) < 11);
    end
  end

  always @(posedge clk) begin
    frame_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected output word");
      end else begin
        e = frame_q.pop_front();
        if (out_tdata !== e.tx_byte)
          report_mismatch($sformatf("tx_byte %h expected %h", out_tdata, e.tx_byte));
        if (out_tlast !== e.last_byte)
          report_mismatch($sformatf("last_byte %b expected %b", out_tlast, e.last_byte));
      end
    end
  end

  int stuck = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off) stuck = 0;
    else stuck++;
    if (stuck > 5000) begin
      $display("ibus_to_crsf_channel_bridge_unit_tb failed");
      $finish;
    end
  end

  initial begin
    addr_m = ADDR_RESET;
    phase_m = HUNT_SYNC1;
    pos_m = 5'd0;
    sum_m = 16'hFFFF;
    low_m = 8'd0;
    for (int i = 0; i < NUM_STAGED; i++) raw_m[i] = 16'd0;
    for (int i = 0; i < NUM_OUT_CH; i++) chan_m[i] = CH_RESET;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    wait_drained();
    write_address(8'h00);
    test_bad_checksum();
    test_random(4);
    wait_drained();
    write_address(8'hFF);
    test_backpressure();
    test_random(4);
    wait_drained();
    write_address(8'($urandom));
    test_random(4);
    wait_drained();
    if (errors == 0) $display("ibus_to_crsf_channel_bridge_unit_tb passed");
    else $display("ibus_to_crsf_channel_bridge_unit_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
